// ===== rtl/core/bfis_pkg.sv =====
`default_nettype none
package bfis_pkg;

	localparam int TAPE_CELLS = 1024;
	localparam int TAPE_AW = $clog2(TAPE_CELLS);
	localparam int LOOP_STACK_DEPTH = 256;
	localparam int STACK_AW = $clog2(LOOP_STACK_DEPTH);
	localparam int STACK_CW = $clog2(LOOP_STACK_DEPTH + 1);
	localparam int PROGRAM_INDEX_BITS = 16;
	localparam int SKIP_W = 16;

	typedef logic [TAPE_AW-1:0] tape_addr_t;
	typedef logic [STACK_CW-1:0] stack_cnt_t;
	typedef logic [PROGRAM_INDEX_BITS-1:0] pidx_t;
	typedef logic [SKIP_W-1:0] skip_t;

	localparam tape_addr_t TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
	localparam stack_cnt_t STACK_FULL = STACK_CW'(LOOP_STACK_DEPTH);
	localparam skip_t SKIP_MAX = '1;

	localparam logic [7:0] OP_RIGHT = 8'h3E;
	localparam logic [7:0] OP_LEFT  = 8'h3C;
	localparam logic [7:0] OP_INC   = 8'h2B;
	localparam logic [7:0] OP_DEC   = 8'h2D;
	localparam logic [7:0] OP_OUT   = 8'h2E;
	localparam logic [7:0] OP_IN    = 8'h2C;
	localparam logic [7:0] OP_OPEN  = 8'h5B;
	localparam logic [7:0] OP_CLOSE = 8'h5D;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_SKIP_OVF = 2'd3
	} status_t;

	typedef struct packed {
		logic       en;
		tape_addr_t addr;
		logic [7:0] data;
	} tape_wr_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		pidx_t data;
	} stack_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfis_tape.sv =====
`default_nettype none
module bfis_tape (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    rd_en,
	input  bfis_pkg::tape_addr_t   rd_addr,
	input  bfis_pkg::tape_wr_t     wr,
	output logic [7:0]             rd_data,
	output logic                   busy
);

	logic [7:0]           mem [bfis_pkg::TAPE_CELLS];
	logic [7:0]           rdata_q;
	logic                 byp_q;
	logic [7:0]           bypd_q;
	bfis_pkg::tape_addr_t clr_cnt_q;
	logic                 clr_busy_q;

	// zeroing sweep after reset, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == bfis_pkg::TAPE_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= 8'h00;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			bypd_q  <= wr.data;
		end
	end

	// read of the cell being written in the same cycle takes the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr.en && !clr_busy_q && (wr.addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? bypd_q : rdata_q;
	assign busy    = clr_busy_q;

endmodule
`default_nettype wire

// ===== rtl/core/bfis_stack.sv =====
`default_nettype none
module bfis_stack (
	input  wire                    clk,
	input  wire                    arst_n,
	input  bfis_pkg::stack_op_t    op,
	output bfis_pkg::stack_cnt_t   count,
	output bfis_pkg::pidx_t        top
);

	bfis_pkg::pidx_t              mem [bfis_pkg::LOOP_STACK_DEPTH];
	bfis_pkg::stack_cnt_t         cnt_q;
	bfis_pkg::stack_cnt_t         cnt_d;
	bfis_pkg::stack_cnt_t         top_idx;
	logic [bfis_pkg::STACK_AW-1:0] rd_addr;
	bfis_pkg::pidx_t              rd_q;
	logic                         byp_q;
	bfis_pkg::pidx_t              bypd_q;

	always_comb begin
		priority if (op.push) begin
			cnt_d = cnt_q + 1'b1;
		end else if (op.pop) begin
			cnt_d = cnt_q - 1'b1;
		end else begin
			cnt_d = cnt_q;
		end
	end

	// keep the top entry of the next count read out every cycle
	assign top_idx = cnt_d - bfis_pkg::STACK_CW'(1);
	assign rd_addr = top_idx[bfis_pkg::STACK_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			byp_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			byp_q <= op.push;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[cnt_q[bfis_pkg::STACK_AW-1:0]] <= op.data;
		end
		rd_q   <= mem[rd_addr];
		bypd_q <= op.data;
	end

	assign top   = byp_q ? bypd_q : rd_q;
	assign count = cnt_q;

endmodule
`default_nettype wire

// ===== rtl/core/brainfuck_instruction_step.sv =====
// instruction goes to s1, then to the result register; result_stall can hold it in s1
// throughput: one instruction per cycle if not stalled, set by the one tape RMW port
// tape reads are issued at transfer time and written back when the result is loaded
// reset: tape is zeroed by sweeping all TAPE_CELLS (1024) cells with item_stall high
// reset: pointer, program index, stack count and skip depth clear at once
`default_nettype none
module brainfuck_instruction_step (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire  [7:0]  opcode,
	input  wire  [7:0]  in_byte,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [15:0] next_index,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic [1:0]  status
);

	logic                 valid_s1;
	logic [7:0]           opcode_s1;
	logic [7:0]           in_byte_s1;

	bfis_pkg::tape_addr_t ptr_q;
	bfis_pkg::pidx_t      pc_q;
	bfis_pkg::skip_t      skip_q;

	logic                 res_valid_q;
	logic [15:0]          next_index_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	bfis_pkg::status_t    status_q;

	logic                 accept;
	logic                 advance;
	logic                 busy;
	logic [7:0]           tape_rd;
	bfis_pkg::tape_addr_t rd_addr;
	bfis_pkg::tape_wr_t   tape_wr;
	bfis_pkg::stack_op_t  stack_op;
	bfis_pkg::stack_cnt_t stack_cnt;
	bfis_pkg::pidx_t      stack_top;

	bfis_pkg::tape_addr_t ptr_nx;
	bfis_pkg::skip_t      skip_nx;
	bfis_pkg::pidx_t      pc_base;
	bfis_pkg::pidx_t      pc_nx;
	logic                 wr_en;
	logic [7:0]           wr_data;
	logic                 push;
	logic                 pop;
	logic                 jump;
	logic                 jump_empty;
	logic                 emit;
	bfis_pkg::status_t    st_nx;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = busy || (valid_s1 && !advance);
	assign accept     = item_valid && !item_stall;

	// read address follows the pointer left by the instruction retiring this cycle
	assign rd_addr = advance ? ptr_nx : ptr_q;

	bfis_tape u_tape (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (tape_wr),
		.rd_data (tape_rd),
		.busy    (busy)
	);

	bfis_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (stack_op),
		.count  (stack_cnt),
		.top    (stack_top)
	);

	always_comb begin
		ptr_nx     = ptr_q;
		skip_nx    = skip_q;
		wr_en      = 1'b0;
		wr_data    = tape_rd;
		push       = 1'b0;
		pop        = 1'b0;
		jump       = 1'b0;
		jump_empty = 1'b0;
		emit       = 1'b0;
		st_nx      = bfis_pkg::ST_OK;
		if (skip_q != '0) begin
			// skipping a loop body: only brackets count
			if (opcode_s1 == bfis_pkg::OP_OPEN) begin
				if (skip_q == bfis_pkg::SKIP_MAX) begin
					st_nx = bfis_pkg::ST_SKIP_OVF;
				end else begin
					skip_nx = skip_q + 1'b1;
				end
			end else if (opcode_s1 == bfis_pkg::OP_CLOSE) begin
				skip_nx = skip_q - 1'b1;
			end
		end else begin
			unique case (opcode_s1)
				bfis_pkg::OP_RIGHT: begin
					ptr_nx = (ptr_q == bfis_pkg::TAPE_LAST) ? '0 : ptr_q + 1'b1;
				end
				bfis_pkg::OP_LEFT: begin
					ptr_nx = (ptr_q == '0) ? bfis_pkg::TAPE_LAST : ptr_q - 1'b1;
				end
				bfis_pkg::OP_INC: begin
					wr_en   = 1'b1;
					wr_data = tape_rd + 8'd1;
				end
				bfis_pkg::OP_DEC: begin
					wr_en   = 1'b1;
					wr_data = tape_rd - 8'd1;
				end
				bfis_pkg::OP_OUT: begin
					emit = 1'b1;
				end
				bfis_pkg::OP_IN: begin
					wr_en   = 1'b1;
					wr_data = in_byte_s1;
				end
				bfis_pkg::OP_OPEN: begin
					if (tape_rd == 8'd0) begin
						skip_nx = bfis_pkg::skip_t'(1);
					end else if (stack_cnt == bfis_pkg::STACK_FULL) begin
						st_nx = bfis_pkg::ST_FULL;
					end else begin
						push = 1'b1;
					end
				end
				bfis_pkg::OP_CLOSE: begin
					if (tape_rd != 8'd0) begin
						if (stack_cnt == '0) begin
							jump_empty = 1'b1;
							st_nx      = bfis_pkg::ST_EMPTY;
						end else begin
							jump = 1'b1;
						end
					end else if (stack_cnt == '0) begin
						st_nx = bfis_pkg::ST_EMPTY;
					end else begin
						pop = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// an empty-stack jump reads the top as all ones, wrapping the next index to zero
	always_comb begin
		priority if (jump_empty) begin
			pc_base = '1;
		end else if (jump) begin
			pc_base = stack_top;
		end else begin
			pc_base = pc_q;
		end
	end

	assign pc_nx = pc_base + 1'b1;

	assign tape_wr.en   = advance && wr_en;
	assign tape_wr.addr = ptr_q;
	assign tape_wr.data = wr_data;

	assign stack_op.push = advance && push;
	assign stack_op.pop  = advance && pop;
	assign stack_op.data = pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			ptr_q       <= '0;
			pc_q        <= '0;
			skip_q      <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				ptr_q       <= ptr_nx;
				pc_q        <= pc_nx;
				skip_q      <= skip_nx;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1  <= opcode;
			in_byte_s1 <= in_byte;
		end
		if (advance) begin
			next_index_q <= 16'(pc_nx);
			out_valid_q  <= emit;
			out_byte_q   <= emit ? tape_rd : 8'd0;
			status_q     <= st_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign next_index   = next_index_q;
	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// ===== sim/bfis_checker.sv =====
`timescale 1ns / 1ps
module bfis_checker
	import bfis_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	input  wire        item_stall,
	input  wire [7:0]  opcode,
	input  wire [7:0]  in_byte,
	input  wire        result_valid,
	input  wire        result_stall,
	input  wire [15:0] next_index,
	input  wire        out_valid,
	input  wire [7:0]  out_byte,
	input  wire [1:0]  status,
	output int         errors,
	output int         outstanding
);

	typedef struct packed {
		pidx_t      index;
		logic       emit;
		logic [7:0] data;
		status_t    st;
	} step_result_t;

	logic [7:0] tape [TAPE_CELLS];
	pidx_t      loops [LOOP_STACK_DEPTH];
	tape_addr_t ptr;
	pidx_t      pidx;
	stack_cnt_t depth;
	skip_t      skip;

	step_result_t expected_q [$];

	task automatic execute_step(input logic [7:0] op, input logic [7:0] data_in,
			output step_result_t r);
		r.index = '0;
		r.emit = 1'b0;
		r.data = 8'h00;
		r.st = ST_OK;
		if (skip != '0) begin
			// inside a skipped loop body only brackets move the depth
			if (op == OP_OPEN) begin
				if (skip == SKIP_MAX)
					r.st = ST_SKIP_OVF;
				else
					skip = skip + 1'b1;
			end else if (op == OP_CLOSE) begin
				skip = skip - 1'b1;
			end
		end else begin
			case (op)
				OP_RIGHT: ptr = (ptr == TAPE_LAST) ? '0 : ptr + 1'b1;
				OP_LEFT:  ptr = (ptr == '0) ? TAPE_LAST : ptr - 1'b1;
				OP_INC:   tape[ptr] = tape[ptr] + 8'd1;
				OP_DEC:   tape[ptr] = tape[ptr] - 8'd1;
				OP_IN:    tape[ptr] = data_in;
				OP_OUT: begin
					r.emit = 1'b1;
					r.data = tape[ptr];
				end
				OP_OPEN: begin
					if (tape[ptr] == 8'h00)
						skip = skip_t'(1);
					else if (depth == STACK_FULL)
						r.st = ST_FULL;
					else begin
						loops[depth[STACK_AW-1:0]] = pidx;
						depth = depth + 1'b1;
					end
				end
				OP_CLOSE: begin
					if (tape[ptr] != 8'h00) begin
						// empty stack reads as all ones, so the index wraps to zero
						if (depth == '0) begin
							pidx = '1;
							r.st = ST_EMPTY;
						end else begin
							pidx = loops[STACK_AW'(depth - 1'b1)];
						end
					end else if (depth == '0) begin
						r.st = ST_EMPTY;
					end else begin
						depth = depth - 1'b1;
					end
				end
				default: ;
			endcase
		end
		pidx = pidx + 1'b1;
		r.index = pidx;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		step_result_t want;
		step_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < TAPE_CELLS; i++)
				tape[i] = 8'h00;
			ptr = '0;
			pidx = '0;
			depth = '0;
			skip = '0;
			expected_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// results at this edge come from earlier transfers, so compare first
			if (result_valid && !result_stall) begin
				got.index = next_index;
				got.emit = out_valid;
				got.data = out_byte;
				got.st = status_t'(status);
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with none pending: %s %h %b %h %0d",
							$realtime, "index/valid/byte/status", next_index,
							out_valid, out_byte, status);
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch: expected index %h valid %b %s %h %0d",
								$realtime, want.index, want.emit, "byte/status",
								want.data, want.st);
							$display("%0t:           got index %h valid %b %s %h %0d",
								$realtime, got.index, got.emit, "byte/status",
								got.data, got.st);
						end
					end
				end
			end
			if (item_valid && !item_stall) begin
				execute_step(opcode, in_byte, want);
				expected_q.push_back(want);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import bfis_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int ITEMS = 1550;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  opcode = 8'h00;
	logic [7:0]  in_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] next_index;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic [1:0]  status;

	int   errors;
	int   outstanding;
	int   cycle_count = 0;
	int   sent = 0;
	logic quiet = 1'b0;

	brainfuck_instruction_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.in_byte(in_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_index(next_index),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.status(status)
	);

	bfis_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.in_byte(in_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_index(next_index),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.status(status),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// result side: random stall before each transfer, none in quiet stretches
	initial begin : receiver
		int hold;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 13);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	task automatic send_item(input logic [7:0] op, input logic [7:0] data);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		in_byte <= data;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	// hold off the sender until the block has returned everything
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] cell_op();
		case ($urandom_range(0, 5))
			0: return OP_RIGHT;
			1: return OP_LEFT;
			2: return OP_INC;
			3: return OP_DEC;
			4: return OP_OUT;
			default: return OP_IN;
		endcase
	endfunction

	initial begin : stimulus
		int body;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: wraps, empty stack, push and jump back, skip, no-ops
		send_item(OP_OUT, 8'h00);
		send_item(OP_DEC, 8'hFF);
		send_item(OP_OUT, 8'h00);
		send_item(OP_INC, 8'h00);
		send_item(OP_LEFT, 8'h00);
		send_item(OP_IN, 8'hA5);
		send_item(OP_OUT, 8'h00);
		send_item(OP_RIGHT, 8'h00);
		send_item(OP_OUT, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_INC, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_OPEN, 8'h00);
		send_item(OP_IN, 8'hFF);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_IN, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_OPEN, 8'h00);
		send_item(OP_INC, 8'h00);
		send_item(OP_OPEN, 8'h00);
		send_item(OP_OUT, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(8'h00, 8'hFF);
		send_item(8'hFF, 8'h00);
		send_item(OP_OUT, 8'h00);
		drain();

		// fill the loop stack one past full, then pop it one past empty
		send_item(OP_IN, 8'h01);
		repeat (LOOP_STACK_DEPTH + 1) send_item(OP_OPEN, 8'h00);
		send_item(OP_CLOSE, 8'h00);
		send_item(OP_IN, 8'h00);
		repeat (LOOP_STACK_DEPTH + 1) send_item(OP_CLOSE, 8'h00);
		drain();

		while (sent < ITEMS) begin
			if ($urandom_range(0, 47) == 0)
				quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_item(cell_op(), 8'($urandom_range(0, 255)));
				4, 5, 6, 7, 8: begin
					// loop fragment with a random entry cell, sometimes zero
					send_item(OP_IN, ($urandom_range(0, 3) == 0) ? 8'h00 :
						8'($urandom_range(0, 255)));
					send_item(OP_OPEN, 8'h00);
					body = $urandom_range(0, 6);
					repeat (body) begin
						if ($urandom_range(0, 7) == 0) begin
							send_item(OP_OPEN, 8'h00);
							send_item(OP_CLOSE, 8'h00);
						end else begin
							send_item(cell_op(), 8'($urandom_range(0, 255)));
						end
					end
					if ($urandom_range(0, 1) == 0)
						send_item(OP_IN, 8'h00);
					send_item(OP_CLOSE, 8'h00);
				end
				default: begin
					case ($urandom_range(0, 2))
						0: send_item(OP_CLOSE, 8'($urandom_range(0, 255)));
						1: send_item(OP_OPEN, 8'($urandom_range(0, 255)));
						default: send_item(8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)));
					endcase
				end
			endcase
		end

		drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
